// ===== design/osaa_pkg.sv =====
// Shared types, codes and constants for the overhang support area accumulator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package osaa_pkg;

    localparam int DEF_COORD_BITS = 24;

    localparam int NORM_W  = 16;
    localparam int COEF_W  = 16;
    localparam int THR_W   = 15;
    localparam int AREA_W  = 52;
    localparam int TOTAL_W = 63;
    localparam int OUT_W   = 120;   // area + total, padded to whole bytes
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Multiplier and accumulator widths
    localparam int MOP_W   = 35;
    localparam int PROD_W  = 2 * MOP_W;
    localparam int CROSS_W = 68;
    localparam int HALF_W  = 34;
    localparam int SUMSQ_W = 136;
    localparam int ROOT_W  = 53;
    localparam int REM_W   = 56;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int LIMIT_BIT  = 106;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TILT_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_Z = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 8'd3;

    localparam logic signed [COEF_W-1:0] TILT_X_RST = 16'sd0;
    localparam logic signed [COEF_W-1:0] TILT_Y_RST = 16'sd0;
    localparam logic signed [COEF_W-1:0] TILT_Z_RST = 16'sd32767;
    localparam logic [THR_W-1:0]         THRESH_RST = 15'd23170;

    // Multiply operation codes
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_TZ_X   = 5'd0;
    localparam logic [OP_W-1:0] OP_TZ_Y   = 5'd1;
    localparam logic [OP_W-1:0] OP_TZ_Z   = 5'd2;
    localparam logic [OP_W-1:0] OP_CX_P   = 5'd3;
    localparam logic [OP_W-1:0] OP_CX_N   = 5'd4;
    localparam logic [OP_W-1:0] OP_CY_P   = 5'd5;
    localparam logic [OP_W-1:0] OP_CY_N   = 5'd6;
    localparam logic [OP_W-1:0] OP_CZ_P   = 5'd7;
    localparam logic [OP_W-1:0] OP_CZ_N   = 5'd8;
    localparam logic [OP_W-1:0] OP_SQX_LL = 5'd9;
    localparam logic [OP_W-1:0] OP_SQX_HL = 5'd10;
    localparam logic [OP_W-1:0] OP_SQX_HH = 5'd11;
    localparam logic [OP_W-1:0] OP_SQY_LL = 5'd12;
    localparam logic [OP_W-1:0] OP_SQY_HL = 5'd13;
    localparam logic [OP_W-1:0] OP_SQY_HH = 5'd14;
    localparam logic [OP_W-1:0] OP_SQZ_LL = 5'd15;
    localparam logic [OP_W-1:0] OP_SQZ_HL = 5'd16;
    localparam logic [OP_W-1:0] OP_SQZ_HH = 5'd17;
    localparam logic [OP_W-1:0] OP_SQ_BASE = OP_SQX_LL;
    localparam int OPS_PER_PHASE = 9;

    typedef struct packed {
        logic            load;
        logic            mul_en;
        logic [OP_W-1:0] op;
        logic            abs_en;
        logic            sqrt_init;
        logic            sqrt_step;
        logic            finish;
    } osaa_cmd_t;

    typedef struct packed {
        logic out_busy;
    } osaa_status_t;

endpackage

`default_nettype wire

// ===== design/osaa_ctrl.sv =====
// Controller for the overhang support area accumulator: sequences the
// multiply phases, the square root and the result write. Uses osaa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module osaa_ctrl
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  osaa_pkg::osaa_status_t status,
    output osaa_pkg::osaa_cmd_t    cmd
);
    import osaa_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_DRN1 = 4'd2;
    localparam logic [3:0] S_ABS  = 4'd3;
    localparam logic [3:0] S_MUL2 = 4'd4;
    localparam logic [3:0] S_DRN2 = 4'd5;
    localparam logic [3:0] S_SQI  = 4'd6;
    localparam logic [3:0] S_SQRT = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    localparam logic [5:0] LAST_OP   = 6'(OPS_PER_PHASE - 1);
    localparam logic [5:0] LAST_SQRT = 6'(SQRT_STEPS - 1);

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    // Advance state and step counter, and drive the commands and in_ready
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul_en = 1'b1;
                cmd.op     = cnt_reg[OP_W-1:0];
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == LAST_OP)
                    state_next = S_DRN1;
            end
            S_DRN1:
                state_next = S_ABS;
            S_ABS:
            begin
                cmd.abs_en = 1'b1;
                cnt_next   = '0;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en = 1'b1;
                cmd.op     = OP_SQ_BASE + cnt_reg[OP_W-1:0];
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == LAST_OP)
                    state_next = S_DRN2;
            end
            S_DRN2:
                state_next = S_SQI;
            S_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == LAST_SQRT)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/osaa_dp.sv =====
// Datapath for the overhang support area accumulator: configuration registers,
// shared multiplier, accumulators, digit-by-digit square root and result
// register. Uses osaa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module osaa_dp
#(
    parameter int COORD_BITS = osaa_pkg::DEF_COORD_BITS
)
(
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  osaa_pkg::osaa_cmd_t                      cmd,
    output osaa_pkg::osaa_status_t                   status,
    input  wire  [3*osaa_pkg::NORM_W+9*COORD_BITS-1:0] in_fields,
    input  wire                                      cfg_valid,
    input  wire  [osaa_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire  [osaa_pkg::CFG_DATA_W-1:0]          cfg_data,
    output logic                                     out_valid,
    input  wire                                      out_ready,
    output logic [osaa_pkg::AREA_W-1:0]              facet_area,
    output logic                                     facet_counted,
    output logic [osaa_pkg::TOTAL_W-1:0]             support_total
);
    import osaa_pkg::*;

    localparam int DW   = COORD_BITS + 1;
    localparam int VB   = 3 * NORM_W;

    // Configuration
    logic signed [COEF_W-1:0] tilt_x_reg, tilt_y_reg, tilt_z_reg;
    logic [THR_W-1:0]         thr_reg;
    logic                     cfg_hit;

    // Item operands
    logic signed [NORM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [DW-1:0]     ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;

    // Multiplier and accumulators
    logic signed [MOP_W-1:0]   opa, opb;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      mv_reg;
    logic [OP_W-1:0]           mop_reg;
    logic signed [MOP_W-1:0]   tz_reg;
    logic signed [CROSS_W-1:0] cr_reg [3];
    logic [SUMSQ_W-1:0]        sq_reg;
    logic [SUMSQ_W-1:0]        sq_term;

    // Square root
    logic              sat_reg;
    logic [REM_W-1:0]  rem_reg, rem_t, trial;
    logic [ROOT_W-1:0] root_reg;
    logic              ge;

    // Result
    logic                 out_valid_reg;
    logic [AREA_W-1:0]    area_reg, area_val;
    logic                 counted_reg, counted_val;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W:0]     total_sum;
    logic signed [MOP_W:0] thr_sum;

    assign cfg_hit = cfg_valid && (cfg_index == REG_TILT_X || cfg_index == REG_TILT_Y ||
                                   cfg_index == REG_TILT_Z || cfg_index == REG_THRESH);

    // Unpack vertex fields
    assign ax = in_fields[VB+0*COORD_BITS +: COORD_BITS];
    assign ay = in_fields[VB+1*COORD_BITS +: COORD_BITS];
    assign az = in_fields[VB+2*COORD_BITS +: COORD_BITS];
    assign bx = in_fields[VB+3*COORD_BITS +: COORD_BITS];
    assign by = in_fields[VB+4*COORD_BITS +: COORD_BITS];
    assign bz = in_fields[VB+5*COORD_BITS +: COORD_BITS];
    assign cx = in_fields[VB+6*COORD_BITS +: COORD_BITS];
    assign cy = in_fields[VB+7*COORD_BITS +: COORD_BITS];
    assign cz = in_fields[VB+8*COORD_BITS +: COORD_BITS];

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_x_reg <= TILT_X_RST;
            tilt_y_reg <= TILT_Y_RST;
            tilt_z_reg <= TILT_Z_RST;
            thr_reg    <= THRESH_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TILT_X: tilt_x_reg <= cfg_data;
                REG_TILT_Y: tilt_y_reg <= cfg_data;
                REG_TILT_Z: tilt_z_reg <= cfg_data;
                REG_THRESH: thr_reg    <= cfg_data[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    // Latch normals and edge vectors
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            nx_reg <= in_fields[0*NORM_W +: NORM_W];
            ny_reg <= in_fields[1*NORM_W +: NORM_W];
            nz_reg <= in_fields[2*NORM_W +: NORM_W];
            ux_reg <= DW'(bx) - DW'(ax);
            uy_reg <= DW'(by) - DW'(ay);
            uz_reg <= DW'(bz) - DW'(az);
            vx_reg <= DW'(cx) - DW'(ax);
            vy_reg <= DW'(cy) - DW'(ay);
            vz_reg <= DW'(cz) - DW'(az);
        end
    end

    // Select multiplier operands
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (cmd.op)
            OP_TZ_X: begin opa = MOP_W'(tilt_x_reg); opb = MOP_W'(nx_reg); end
            OP_TZ_Y: begin opa = MOP_W'(tilt_y_reg); opb = MOP_W'(ny_reg); end
            OP_TZ_Z: begin opa = MOP_W'(tilt_z_reg); opb = MOP_W'(nz_reg); end
            OP_CX_P: begin opa = MOP_W'(uy_reg); opb = MOP_W'(vz_reg); end
            OP_CX_N: begin opa = MOP_W'(uz_reg); opb = MOP_W'(vy_reg); end
            OP_CY_P: begin opa = MOP_W'(uz_reg); opb = MOP_W'(vx_reg); end
            OP_CY_N: begin opa = MOP_W'(ux_reg); opb = MOP_W'(vz_reg); end
            OP_CZ_P: begin opa = MOP_W'(ux_reg); opb = MOP_W'(vy_reg); end
            OP_CZ_N: begin opa = MOP_W'(uy_reg); opb = MOP_W'(vx_reg); end
            OP_SQX_LL:
            begin
                opa = MOP_W'(cr_reg[0][HALF_W-1:0]); opb = MOP_W'(cr_reg[0][HALF_W-1:0]);
            end
            OP_SQX_HL:
            begin
                opa = MOP_W'(cr_reg[0][CROSS_W-1:HALF_W]); opb = MOP_W'(cr_reg[0][HALF_W-1:0]);
            end
            OP_SQX_HH:
            begin
                opa = MOP_W'(cr_reg[0][CROSS_W-1:HALF_W]);
                opb = MOP_W'(cr_reg[0][CROSS_W-1:HALF_W]);
            end
            OP_SQY_LL:
            begin
                opa = MOP_W'(cr_reg[1][HALF_W-1:0]); opb = MOP_W'(cr_reg[1][HALF_W-1:0]);
            end
            OP_SQY_HL:
            begin
                opa = MOP_W'(cr_reg[1][CROSS_W-1:HALF_W]); opb = MOP_W'(cr_reg[1][HALF_W-1:0]);
            end
            OP_SQY_HH:
            begin
                opa = MOP_W'(cr_reg[1][CROSS_W-1:HALF_W]);
                opb = MOP_W'(cr_reg[1][CROSS_W-1:HALF_W]);
            end
            OP_SQZ_LL:
            begin
                opa = MOP_W'(cr_reg[2][HALF_W-1:0]); opb = MOP_W'(cr_reg[2][HALF_W-1:0]);
            end
            OP_SQZ_HL:
            begin
                opa = MOP_W'(cr_reg[2][CROSS_W-1:HALF_W]); opb = MOP_W'(cr_reg[2][HALF_W-1:0]);
            end
            OP_SQZ_HH:
            begin
                opa = MOP_W'(cr_reg[2][CROSS_W-1:HALF_W]);
                opb = MOP_W'(cr_reg[2][CROSS_W-1:HALF_W]);
            end
            default: ;
        endcase
    end

    // Register the product and its operation code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else
            mv_reg <= cmd.mul_en;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        mop_reg  <= cmd.op;
    end

    // Place a square term at its weight; the cross term counts twice
    always_comb
    begin
        sq_term = SUMSQ_W'(prod_reg[CROSS_W-1:0]);
        case (mop_reg)
            OP_SQX_HL, OP_SQY_HL, OP_SQZ_HL: sq_term = sq_term << (HALF_W + 1);
            OP_SQX_HH, OP_SQY_HH, OP_SQZ_HH: sq_term = sq_term << (2 * HALF_W);
            default: ;
        endcase
    end

    // Accumulate products, take magnitudes, run the square root
    assign rem_t = {rem_reg[REM_W-3:0], sq_reg[LIMIT_BIT-1:LIMIT_BIT-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tz_reg    <= '0;
            cr_reg[0] <= '0;
            cr_reg[1] <= '0;
            cr_reg[2] <= '0;
            sq_reg    <= '0;
        end
        else if (mv_reg)
        begin
            case (mop_reg)
                OP_TZ_X, OP_TZ_Y, OP_TZ_Z: tz_reg <= tz_reg + prod_reg[MOP_W-1:0];
                OP_CX_P: cr_reg[0] <= cr_reg[0] + prod_reg[CROSS_W-1:0];
                OP_CX_N: cr_reg[0] <= cr_reg[0] - prod_reg[CROSS_W-1:0];
                OP_CY_P: cr_reg[1] <= cr_reg[1] + prod_reg[CROSS_W-1:0];
                OP_CY_N: cr_reg[1] <= cr_reg[1] - prod_reg[CROSS_W-1:0];
                OP_CZ_P: cr_reg[2] <= cr_reg[2] + prod_reg[CROSS_W-1:0];
                OP_CZ_N: cr_reg[2] <= cr_reg[2] - prod_reg[CROSS_W-1:0];
                default: sq_reg <= sq_reg + sq_term;
            endcase
        end
        else if (cmd.abs_en)
        begin
            cr_reg[0] <= cr_reg[0][CROSS_W-1] ? -cr_reg[0] : cr_reg[0];
            cr_reg[1] <= cr_reg[1][CROSS_W-1] ? -cr_reg[1] : cr_reg[1];
            cr_reg[2] <= cr_reg[2][CROSS_W-1] ? -cr_reg[2] : cr_reg[2];
        end
        else if (cmd.sqrt_init)
        begin
            sat_reg  <= sq_reg[SUMSQ_W-1:LIMIT_BIT] != '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rem_reg  <= ge ? rem_t - trial : rem_t;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            sq_reg   <= sq_reg << 2;
        end
    end

    // Build the result
    assign thr_sum     = (MOP_W+1)'(tz_reg) + (MOP_W+1)'({thr_reg, 15'd0});
    assign counted_val = thr_sum[MOP_W];
    assign area_val    = sat_reg ? {AREA_W{1'b1}} : root_reg[ROOT_W-1:1];
    assign total_sum   = {1'b0, total_reg} + (TOTAL_W+1)'(area_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_hit)
                total_reg <= '0;
            else if (cmd.finish && counted_val)
                total_reg <= total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            area_reg    <= area_val;
            counted_reg <= counted_val;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign facet_area      = area_reg;
    assign facet_counted   = counted_reg;
    assign support_total   = total_reg;

endmodule

`default_nettype wire

// ===== design/overhang_support_area_accumulator.sv =====
// Top level of the overhang support area accumulator: stream ports, the
// controller and the datapath. Uses osaa_pkg, osaa_ctrl and osaa_dp.
//
//  channel   direction  transaction           payload
//  s_axis    in         s_tvalid & s_tready   facet normal and vertices
//  m_axis    out        m_tvalid & m_tready   area, running total, counted flag
//  cfg       in         cfg_valid & cfg_ready register index and value
//
// From acceptance to a valid result, a facet goes through 9 passes of the
// shared 35x35 multiplier for the tilt and cross products, 9 for the
// squares, 53 steps of the digit-by-digit square root and the drain,
// magnitude, root setup and result write states. The next facet is taken
// only once the previous result has been written to the result register.
// Reset clears the running total and loads the default tilt and threshold.
// A new facet is taken while a result still waits; the finished result waits
// in the datapath only if the previous one has not been taken.
`timescale 1ns / 1ps
`default_nettype none

module overhang_support_area_accumulator
#(
    parameter int COORD_BITS = osaa_pkg::DEF_COORD_BITS
)
(
    input  wire                                          clk,
    input  wire                                          rst_n,
    input  wire                                          s_tvalid,
    output logic                                         s_tready,
    // normal_x, normal_y, normal_z, vert_a_x..z, vert_b_x..z, vert_c_x..z, zero pad
    input  wire  [((3*osaa_pkg::NORM_W+9*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                         m_tvalid,
    input  wire                                          m_tready,
    // facet_area, support_total, zero pad
    output logic [osaa_pkg::OUT_W-1:0]                   m_tdata,
    // facet_counted
    output logic                                         m_tuser,
    input  wire                                          cfg_valid,
    output logic                                         cfg_ready,
    input  wire  [osaa_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  wire  [osaa_pkg::CFG_DATA_W-1:0]              cfg_data
);
    import osaa_pkg::*;

    localparam int FIELDS_W = 3 * NORM_W + 9 * COORD_BITS;

    osaa_cmd_t         cmd;
    osaa_status_t      status;
    logic [AREA_W-1:0]  facet_area;
    logic [TOTAL_W-1:0] support_total;

    assign cfg_ready = 1'b1;

    osaa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    osaa_dp #(.COORD_BITS(COORD_BITS)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_fields     (s_tdata[FIELDS_W-1:0]),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .facet_area    (facet_area),
        .facet_counted (m_tuser),
        .support_total (support_total)
    );

    // Pack the result
    assign m_tdata = {(OUT_W - AREA_W - TOTAL_W)'(0), support_total, facet_area};

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second facet taken while one is at work");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.finish))
        else $error("result shown without a finish command");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_en, cmd.abs_en, cmd.sqrt_init, cmd.sqrt_step,
                  cmd.finish}))
        else $error("controller issued overlapping commands");

    a_finish_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(m_tvalid && !m_tready))
        else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// ===== tb/osaa_checker.sv =====
// Checker for the overhang support area accumulator: watches the facet, result
// and register channels, predicts each result and compares it. Uses osaa_pkg.
`timescale 1ns / 1ps

module osaa_checker
#(
    parameter int CB = osaa_pkg::DEF_COORD_BITS,
    parameter int IN_W = ((3*osaa_pkg::NORM_W+9*CB+7)/8)*8
)
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tvalid,
    input  wire                                s_tready,
    input  wire [IN_W-1:0]                     s_tdata,
    input  wire                                m_tvalid,
    input  wire                                m_tready,
    input  wire [osaa_pkg::OUT_W-1:0]          m_tdata,
    input  wire                                m_tuser,
    input  wire                                cfg_valid,
    input  wire                                cfg_ready,
    input  wire [osaa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [osaa_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 counted_seen
);
    import osaa_pkg::*;

    typedef struct {
        logic [AREA_W-1:0]  area;
        logic               counted;
        logic [TOTAL_W-1:0] total;
    } facet_result_t;

    localparam logic [AREA_W-1:0]  AREA_SAT  = {AREA_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_SAT = {TOTAL_W{1'b1}};

    facet_result_t expected_results[$];

    logic signed [COEF_W-1:0] coef_x, coef_y, coef_z;
    logic [THR_W-1:0]         threshold;
    logic [TOTAL_W-1:0]       running_total;

    // Exact facet area: floor(sqrt(|u x v|^2) / 2), saturating
    function automatic logic [AREA_W-1:0] exact_area(input logic [IN_W-1:0] d);
        logic signed [CB-1:0]   p [9];
        logic signed [CB+1:0]   ux, uy, uz, vx, vy, vz;
        logic signed [2*CB+7:0] cx, cy, cz;
        logic signed [127:0]    wx, wy, wz;
        logic [127:0]           sumsq, sq;
        logic [ROOT_W-1:0]      root, cand;
        for (int i = 0; i < 9; i++)
            p[i] = d[3*NORM_W + i*CB +: CB];
        ux = p[3] - p[0]; uy = p[4] - p[1]; uz = p[5] - p[2];
        vx = p[6] - p[0]; vy = p[7] - p[1]; vz = p[8] - p[2];
        cx = uy * vz - uz * vy;
        cy = uz * vx - ux * vz;
        cz = ux * vy - uy * vx;
        wx = cx; wy = cy; wz = cz;
        sumsq = wx * wx + wy * wy + wz * wz;
        if (sumsq >= (128'd1 << LIMIT_BIT))
            return AREA_SAT;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            cand = root | (ROOT_W'(1) << b);
            sq = 128'(cand) * 128'(cand);
            if (sq <= sumsq)
                root = cand;
        end
        return root[ROOT_W-1:1];
    endfunction

    // Tilt the normal, test against the threshold, update the running total
    function automatic facet_result_t predict_facet(input logic [IN_W-1:0] d);
        facet_result_t r;
        logic signed [NORM_W-1:0] nx, ny, nz;
        longint tz;
        logic [TOTAL_W:0] sum;
        nx = d[0 +: NORM_W];
        ny = d[NORM_W +: NORM_W];
        nz = d[2*NORM_W +: NORM_W];
        tz = longint'(coef_x) * longint'(nx) + longint'(coef_y) * longint'(ny)
           + longint'(coef_z) * longint'(nz);
        r.area = exact_area(d);
        r.counted = (-tz) > longint'(threshold) * 64'sd32768;
        if (r.counted)
        begin
            sum = {1'b0, running_total} + (TOTAL_W+1)'(r.area);
            running_total = sum[TOTAL_W] ? TOTAL_SAT : sum[TOTAL_W-1:0];
        end
        r.total = running_total;
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x        = TILT_X_RST;
            coef_y        = TILT_Y_RST;
            coef_z        = TILT_Z_RST;
            threshold     = THRESH_RST;
            running_total = '0;
            fail_count    = 0;
            counted_seen  = 0;
            expected_results.delete();
        end
        else
        begin
            // Compare a finished result with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction");
                    fail_count++;
                end
                else
                begin
                    facet_result_t e;
                    e = expected_results.pop_front();
                    if (m_tdata[0 +: AREA_W] !== e.area)
                    begin
                        $error("facet_area expected %0d actual %0d", e.area,
                               m_tdata[0 +: AREA_W]);
                        fail_count++;
                    end
                    if (m_tuser !== e.counted)
                    begin
                        $error("facet_counted expected %0d actual %0d", e.counted, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[AREA_W +: TOTAL_W] !== e.total)
                    begin
                        $error("support_total expected %0d actual %0d", e.total,
                               m_tdata[AREA_W +: TOTAL_W]);
                        fail_count++;
                    end
                    if (e.counted)
                        counted_seen++;
                end
            end
            // Predict each accepted facet
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_facet(s_tdata));
            // Register writes; any known index clears the total
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TILT_X: coef_x = cfg_data;
                    REG_TILT_Y: coef_y = cfg_data;
                    REG_TILT_Z: coef_z = cfg_data;
                    REG_THRESH: threshold = cfg_data[THR_W-1:0];
                    default: ;
                endcase
                if (cfg_index <= REG_THRESH)
                    running_total = '0;
            end
        end
    end

endmodule

// ===== tb/overhang_support_area_accumulator_test.sv =====
// Top of the overhang support area accumulator testbench: clock, reset,
// facet and register stimulus, verdict. Uses osaa_pkg and osaa_checker.
`timescale 1ns / 1ps

module overhang_support_area_accumulator_test;
    import osaa_pkg::*;

    localparam int CB   = DEF_COORD_BITS;
    localparam int IN_W = ((3*NORM_W+9*CB+7)/8)*8;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    counted_seen;
    int                    facets_sent;
    int                    cycle_count = 0;
    bit                    no_idle;

    overhang_support_area_accumulator #(.COORD_BITS(CB)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    osaa_checker #(.CB(CB)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .counted_seen(counted_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    // Result side: stall at random before each transaction
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = draw_gap();
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Send one facet; valid stays high when no gap follows
    task automatic send_facet(input logic signed [NORM_W-1:0] n [3],
                              input logic signed [CB-1:0] p [9]);
        int gap;
        logic [IN_W-1:0] d;
        d = '0;
        for (int i = 0; i < 3; i++)
            d[i*NORM_W +: NORM_W] = n[i];
        for (int i = 0; i < 9; i++)
            d[3*NORM_W + i*CB +: CB] = p[i];
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        facets_sent++;
    endtask

    // Write one register; valid is lowered by the caller after the batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Hold off until every result is back and the datapath is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_tilt(input logic [15:0] cx, cy, cz, input logic [15:0] thr);
        write_reg(REG_TILT_X, cx);
        write_reg(REG_TILT_Y, cy);
        write_reg(REG_TILT_Z, cz);
        write_reg(REG_THRESH, thr);
        cfg_valid <= 1'b0;
    endtask

    // Random facet: mostly small meshes, some full-range, some degenerate
    task automatic send_random_facet();
        logic signed [NORM_W-1:0] n [3];
        logic signed [CB-1:0]     p [9];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++)
            n[i] = NORM_W'($urandom);
        for (int i = 0; i < 9; i++)
        begin
            if (kind < 3)
                p[i] = CB'($urandom);
            else
                p[i] = CB'($signed($urandom_range(0, 8191)) - 4096);
        end
        if (kind == 9)
            for (int i = 0; i < 3; i++)
                p[6 + i] = p[3 + i];
        send_facet(n, p);
    endtask

    initial
    begin
        logic signed [NORM_W-1:0] n [3];
        logic signed [CB-1:0]     p [9];
        logic [15:0] thr;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        facets_sent = 0;
        no_idle = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default tilt: downward unit normal counts, upward does not
        n = '{16'sd0, 16'sd0, -16'sd32768};
        p = '{0, 0, 0, 24'sd256, 0, 0, 0, 24'sd256, 0};
        send_facet(n, p);
        n = '{16'sd0, 16'sd0, 16'sd32767};
        send_facet(n, p);
        // Extreme vertices, largest possible triangles
        n = '{16'sd0, 16'sd0, -16'sd32768};
        p = '{-24'sd8388608, -24'sd8388608, -24'sd8388608,
              24'sd8388607, -24'sd8388608, 24'sd8388607,
              -24'sd8388608, 24'sd8388607, 24'sd8388607};
        send_facet(n, p);
        p = '{24'sd8388607, 24'sd8388607, 24'sd8388607,
              -24'sd8388608, 24'sd8388607, -24'sd8388608,
              24'sd8388607, -24'sd8388608, -24'sd8388608};
        send_facet(n, p);
        // Degenerate facets: repeated and collinear vertices
        p = '{24'sd5, 24'sd6, 24'sd7, 24'sd5, 24'sd6, 24'sd7, 24'sd9, 24'sd1, 24'sd3};
        send_facet(n, p);
        p = '{0, 0, 0, 24'sd100, 24'sd200, 24'sd300, 24'sd200, 24'sd400, 24'sd600};
        send_facet(n, p);
        // Non-unit normals, extreme components
        n = '{-16'sd32768, -16'sd32768, -16'sd32768};
        send_facet(n, p);
        n = '{16'sd32767, 16'sd32767, 16'sd32767};
        p = '{0, 0, 0, 24'sd1, 0, 0, 0, 24'sd1, 0};
        send_facet(n, p);
        drain();

        // Threshold equality: tilt_z = -1, so downward component = nz * 2^15
        thr = 16'd12345;
        set_tilt(16'd0, 16'd0, 16'h8000, thr);
        n = '{16'sd0, 16'sd0, 16'sd12345};
        p = '{0, 0, 0, 24'sd1000, 0, 0, 0, 24'sd1000, 0};
        send_facet(n, p);
        n = '{16'sd0, 16'sd0, 16'sd12346};
        send_facet(n, p);
        n = '{16'sd0, 16'sd0, 16'sd12344};
        send_facet(n, p);
        drain();

        // Out-of-range indexes are ignored; upper threshold bit is dropped
        write_reg(8'd4, 16'hFFFF);
        write_reg(8'd255, 16'h1234);
        write_reg(REG_THRESH, 16'hFFFF);
        cfg_valid <= 1'b0;
        n = '{16'sd0, 16'sd0, 16'sd32767};
        send_facet(n, p);
        drain();
        write_reg(REG_THRESH, 16'd0);
        cfg_valid <= 1'b0;
        n = '{16'sd0, 16'sd0, 16'sd1};
        send_facet(n, p);
        n = '{16'sd0, 16'sd0, 16'sd0};
        send_facet(n, p);
        drain();

        // Random phases across several tilt settings
        for (int phase = 0; phase < 8; phase++)
        begin
            no_idle = (phase % 3 == 2);
            case (phase)
                0: set_tilt(16'd0, 16'd0, 16'd32767, 16'd23170);
                1: set_tilt(16'h8000, 16'h8000, 16'h8000, 16'd0);
                2: set_tilt(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
                3: set_tilt(16'h8000, 16'h7FFF, 16'h0000, 16'd16384);
                default: set_tilt(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom));
            endcase
            repeat (118)
                send_random_facet();
            if ($urandom_range(0, 1))
            begin
                drain();
                write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
            end
            drain();
        end

        drain();
        $display("sent %0d facets over 8 tilt settings plus directed cases", facets_sent);
        $display("%0d results counted as overhang", counted_seen);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
